/* rtl/core/ntc_pkg.sv */
// ----------------------------------------------------------------------------
// ntc_pkg
// Types, constants and the resistance table for the NTC temperature converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int TBL_LEN = 166;
    localparam int IDX_W = 8;
    localparam logic signed [7:0] TEMP_FIRST = -8'sd40;
    localparam logic [19:0] REF_RESET = 20'd10000;
    localparam logic [15:0] FS_RESET = 16'd4095;
    localparam logic [0:0] REG_REF = 1'b0;
    localparam logic [0:0] REG_FS = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } div_ctrl_t;

    function automatic logic [18:0] ohm_at(input logic [IDX_W-1:0] i);
        logic [18:0] r;
        case (i)
            8'd0: r = 19'd335745; 8'd1: r = 19'd314213; 8'd2: r = 19'd294198;
            8'd3: r = 19'd275584; 8'd4: r = 19'd258265; 8'd5: r = 19'd242142;
            8'd6: r = 19'd227126; 8'd7: r = 19'd213135; 8'd8: r = 19'd200093;
            8'd9: r = 19'd187929; 8'd10: r = 19'd176580; 8'd11: r = 19'd165987;
            8'd12: r = 19'd156094; 8'd13: r = 19'd146852; 8'd14: r = 19'd138213;
            8'd15: r = 19'd130136; 8'd16: r = 19'd122579; 8'd17: r = 19'd115508;
            8'd18: r = 19'd108887; 8'd19: r = 19'd102687; 8'd20: r = 19'd96876;
            8'd21: r = 19'd91430; 8'd22: r = 19'd86323; 8'd23: r = 19'd81531;
            8'd24: r = 19'd77035; 8'd25: r = 19'd72813; 8'd26: r = 19'd68848;
            8'd27: r = 19'd65123; 8'd28: r = 19'd61621; 8'd29: r = 19'd58328;
            8'd30: r = 19'd55231; 8'd31: r = 19'd52317; 8'd32: r = 19'd49574;
            8'd33: r = 19'd46990; 8'd34: r = 19'd44557; 8'd35: r = 19'd42264;
            8'd36: r = 19'd40102; 8'd37: r = 19'd38064; 8'd38: r = 19'd36141;
            8'd39: r = 19'd34326; 8'd40: r = 19'd32613; 8'd41: r = 19'd30996;
            8'd42: r = 19'd29468; 8'd43: r = 19'd28024; 8'd44: r = 19'd26660;
            8'd45: r = 19'd25370; 8'd46: r = 19'd24149; 8'd47: r = 19'd22994;
            8'd48: r = 19'd21901; 8'd49: r = 19'd20867; 8'd50: r = 19'd19888;
            8'd51: r = 19'd18959; 8'd52: r = 19'd18079; 8'd53: r = 19'd17245;
            8'd54: r = 19'd16454; 8'd55: r = 19'd15704; 8'd56: r = 19'd14993;
            8'd57: r = 19'd14317; 8'd58: r = 19'd13676; 8'd59: r = 19'd13067;
            8'd60: r = 19'd12489; 8'd61: r = 19'd11940; 8'd62: r = 19'd11417;
            8'd63: r = 19'd10921; 8'd64: r = 19'd10449; 8'd65: r = 19'd10000;
            8'd66: r = 19'd9572; 8'd67: r = 19'd9165; 8'd68: r = 19'd8778;
            8'd69: r = 19'd8409; 8'd70: r = 19'd8058; 8'd71: r = 19'd7724;
            8'd72: r = 19'd7405; 8'd73: r = 19'd7101; 8'd74: r = 19'd6811;
            8'd75: r = 19'd6534; 8'd76: r = 19'd6271; 8'd77: r = 19'd6019;
            8'd78: r = 19'd5779; 8'd79: r = 19'd5549; 8'd80: r = 19'd5330;
            8'd81: r = 19'd5121; 8'd82: r = 19'd4921; 8'd83: r = 19'd4730;
            8'd84: r = 19'd4547; 8'd85: r = 19'd4373; 8'd86: r = 19'd4206;
            8'd87: r = 19'd4046; 8'd88: r = 19'd3893; 8'd89: r = 19'd3747;
            8'd90: r = 19'd3607; 8'd91: r = 19'd3473; 8'd92: r = 19'd3345;
            8'd93: r = 19'd3222; 8'd94: r = 19'd3104; 8'd95: r = 19'd2991;
            8'd96: r = 19'd2883; 8'd97: r = 19'd2780; 8'd98: r = 19'd2680;
            8'd99: r = 19'd2585; 8'd100: r = 19'd2493; 8'd101: r = 19'd2405;
            8'd102: r = 19'd2321; 8'd103: r = 19'd2240; 8'd104: r = 19'd2163;
            8'd105: r = 19'd2088; 8'd106: r = 19'd2017; 8'd107: r = 19'd1948;
            8'd108: r = 19'd1882; 8'd109: r = 19'd1818; 8'd110: r = 19'd1757;
            8'd111: r = 19'd1698; 8'd112: r = 19'd1642; 8'd113: r = 19'd1588;
            8'd114: r = 19'd1535; 8'd115: r = 19'd1485; 8'd116: r = 19'd1437;
            8'd117: r = 19'd1390; 8'd118: r = 19'd1345; 8'd119: r = 19'd1302;
            8'd120: r = 19'd1261; 8'd121: r = 19'd1221; 8'd122: r = 19'd1182;
            8'd123: r = 19'd1145; 8'd124: r = 19'd1109; 8'd125: r = 19'd1075;
            8'd126: r = 19'd1041; 8'd127: r = 19'd1008; 8'd128: r = 19'd978;
            8'd129: r = 19'd948; 8'd130: r = 19'd920; 8'd131: r = 19'd892;
            8'd132: r = 19'd865; 8'd133: r = 19'd839; 8'd134: r = 19'd814;
            8'd135: r = 19'd790; 8'd136: r = 19'd767; 8'd137: r = 19'd744;
            8'd138: r = 19'd722; 8'd139: r = 19'd701; 8'd140: r = 19'd681;
            8'd141: r = 19'd662; 8'd142: r = 19'd643; 8'd143: r = 19'd624;
            8'd144: r = 19'd607; 8'd145: r = 19'd589; 8'd146: r = 19'd573;
            8'd147: r = 19'd557; 8'd148: r = 19'd541; 8'd149: r = 19'd526;
            8'd150: r = 19'd512; 8'd151: r = 19'd498; 8'd152: r = 19'd484;
            8'd153: r = 19'd471; 8'd154: r = 19'd458; 8'd155: r = 19'd446;
            8'd156: r = 19'd434; 8'd157: r = 19'd422; 8'd158: r = 19'd411;
            8'd159: r = 19'd400; 8'd160: r = 19'd390; 8'd161: r = 19'd379;
            8'd162: r = 19'd369; 8'd163: r = 19'd360; 8'd164: r = 19'd351;
            8'd165: r = 19'd342;
            default: r = 19'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/ntc_adc_to_temperature.sv */
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature
// Converts an NTC divider ADC sample into whole degrees Celsius.
// ----------------------------------------------------------------------------
// channel | direction | payload
// s_      | in        | adc_sample [15:0]
// m_      | out       | temperature_c [7:0] signed
// cfg_    | in        | cfg_index [0:0], cfg_data [19:0]
// a sample passes through a multiply, a divide and a scan of up to 166 table entries
// the table scan is one compare per cycle, so a hot reading costs most
// zero samples skip straight to the result in the next cycle
// s_ready is high only in idle; the result holds until m_ready
// reset restores the reference resistor and full scale defaults
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature
    import ntc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [15:0]       s_adc_sample,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [7:0] m_temperature_c,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [19:0]       cfg_data
);

    state_t state_reg, state_next;
    logic [19:0] ref_reg;
    logic [15:0] fs_reg;
    logic [15:0] smp_reg;
    logic [31:0] ohms_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic signed [7:0] temp_reg, temp_next;
    logic [31:0] diff;
    logic [51:0] prod_full;
    logic div_start;
    div_ctrl_t div_st;
    logic [31:0] div_q;
    logic hit;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_DONE);
    assign m_temperature_c = temp_reg;

    assign diff      = {16'd0, fs_reg} - {16'd0, smp_reg};
    assign prod_full = ref_reg * diff;
    assign div_start = (state_reg == ST_MUL);
    assign hit       = (ohms_reg >= {13'd0, ohm_at(idx_reg)});

    ntc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_full[31:0]),
        .divisor  (smp_reg),
        .status   (div_st),
        .quotient (div_q)
    );

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        temp_next  = temp_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_adc_sample == 16'd0) begin
                        temp_next  = TEMP_FIRST;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: state_next = ST_DIV;
            ST_DIV: begin
                if (!div_st.busy && !div_st.start) begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    temp_next  = TEMP_FIRST + $signed(idx_reg);
                    state_next = ST_DONE;
                end else if (idx_reg == IDX_W'(TBL_LEN - 1)) begin
                    temp_next  = TEMP_FIRST;
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ref_reg   <= REF_RESET;
            fs_reg    <= FS_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                if (cfg_index == REG_REF) begin
                    ref_reg <= cfg_data;
                end else begin
                    fs_reg <= cfg_data[15:0];
                end
            end
        end
        idx_reg  <= idx_next;
        temp_reg <= temp_next;
        if (state_reg == ST_IDLE && s_valid) begin
            smp_reg <= s_adc_sample;
        end
        if (state_reg == ST_DIV) begin
            ohms_reg <= div_q;
        end
    end

endmodule

/* rtl/core/ntc_div.sv */
// ----------------------------------------------------------------------------
// ntc_div
// Restoring 32 by 16 bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntc_div
    import ntc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output div_ctrl_t   status,
    output logic [31:0] quotient
);

    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dsr_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] shifted;
    logic [17:0] trial;

    assign shifted = {rem_reg[15:0], quo_reg[31]};
    assign trial   = {1'b0, shifted} - {2'b00, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[17]) begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end else begin
                rem_next = trial[16:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign status.start = start;
    assign status.busy  = busy_reg;
    assign quotient     = quo_reg;

endmodule

/* rtl/core/ntc_adc_to_temperature_chk.sv */
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature_chk
// Port-level checks for the NTC temperature converter.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic signed [7:0] m_temperature_c
);

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("ready during conversion");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready)) else $error("result and input both open");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temperature_c >= -8'sd40 && m_temperature_c <= 8'sd125))
        else $error("temperature out of range");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_temperature_c)))
        else $error("result dropped");

endmodule

bind ntc_adc_to_temperature ntc_adc_to_temperature_chk u_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_temperature_c (m_temperature_c)
);
